/* sv/vn3_pkg.sv */
`default_nettype none

package vn3_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int TIME_W  = 32;
    localparam int SCALE_W = 16;
    localparam int Q_W     = 16;
    localparam int COORD_W = 32;

    // fraction bits of the saturated coordinate
    localparam int FRAC_BITS = 16;

    // pos is Q8.16 and scale Q8.8, so the product has 24 fraction bits
    localparam int POS_FRAC  = 16;
    localparam int SCALE_FRAC = 8;
    localparam int PROD_FRAC = POS_FRAC + SCALE_FRAC;
    localparam int PROD_W    = POS_W + SCALE_W + 1;
    localparam int SUM_W     = PROD_W + 8;
    localparam int SCALE_SHR = PROD_FRAC - FRAC_BITS;
    localparam int TA_SHL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int TA_SHR    = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
    localparam int INT_W     = COORD_W - FRAC_BITS;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // corner hash constants
    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KY = 32'd668265263;
    localparam logic [31:0] HASH_KZ = 32'd2147483647;
    localparam logic [31:0] HASH_KM = 32'd1274126177;

    // fade arithmetic
    localparam int FA_W = 22;
    localparam int FP_W = FA_W + Q_W + 1;
    localparam logic signed [FA_W-1:0] FADE_MUL6 = 22'sd6;
    localparam logic signed [FA_W-1:0] FADE_K15  = 22'sd983040;
    localparam logic signed [FA_W-1:0] FADE_K10  = 22'sd655360;
    localparam logic signed [FA_W-1:0] FADE_MAX  = 22'sd65535;

    localparam int STAGES = 9;

endpackage

`default_nettype wire

/* sv/value_noise_3d_unit.sv */
`default_nettype none

// 3d value noise unit: each transfer on the input channel carries a point (signed
// q8.16 x, y, z) and a time offset (signed q16.16); one q0.16 noise value comes out
// for each point, in order. the point is scaled by coord_scale (unsigned q8.8, reset
// 1.0), the time offset is added to x, and each coordinate saturates to q16.16. the
// eight corners of the unit cube are hashed, the fractions go through the quintic
// fade and the corner values are blended along x, y and z. the unit is a nine-stage
// pipeline: a new point can be taken on every clock while in_stall is low, and its
// result is held in the stage 9 output register until it transfers while the output
// is not stalled. each pipeline stage holds at most one 32-bit multiplier per lane,
// which sets the stage count. a stall on the output only holds back the
// input once every stage is occupied. coord_scale must be written only while the
// pipeline is empty; cfg_ready is always high.
module value_noise_3d_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [vn3_pkg::SCALE_W-1:0]         cfg_data,
    // point input
    input  wire logic                                in_valid,
    output      logic                                in_stall,
    input  wire logic signed [vn3_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [vn3_pkg::POS_W-1:0]    pos_y,
    input  wire logic signed [vn3_pkg::POS_W-1:0]    pos_z,
    input  wire logic signed [vn3_pkg::TIME_W-1:0]   time_offset,
    // noise output
    output      logic                                out_valid,
    input  wire logic                                out_stall,
    output      logic [vn3_pkg::Q_W-1:0]             noise_value
);
    import vn3_pkg::*;

    // floor blend of two q0.16 values by a q0.16 weight
    function automatic logic [Q_W-1:0] lerp(
        input logic [Q_W-1:0] a,
        input logic [Q_W-1:0] b,
        input logic [Q_W-1:0] t
    );
        logic signed [Q_W:0]     d;
        logic signed [2*Q_W+1:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = $signed({1'b0, t}) * d;
        return a + p[2*Q_W-1:Q_W];
    endfunction

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0] coord_scale_reg;
    logic [SCALE_W-1:0] coord_scale_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        coord_scale_next = coord_scale_reg;
        if (cfg_valid && cfg_ready)
        begin
            coord_scale_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_scale_reg <= SCALE_RESET;
        end
        else
        begin
            coord_scale_reg <= coord_scale_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its successor
    // loads, so bubbles collapse behind a stalled output
    // ------------------------------------------------------------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES:0]   en;

    always_comb
    begin
        en[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[STAGES-1];

    // ------------------------------------------------------------------
    // stage 1: scale multiply
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0]  pos_in [3];
    logic signed [PROD_W-1:0] s1_prod_reg  [3];
    logic signed [PROD_W-1:0] s1_prod_next [3];
    logic signed [TIME_W-1:0] s1_time_reg;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s1_prod_next[a] = pos_in[a] * $signed({1'b0, coord_scale_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_prod_reg <= s1_prod_next;
            s1_time_reg <= time_offset;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: align, add time to x, saturate, split into integer and fraction
    // ------------------------------------------------------------------
    logic [INT_W-1:0] s2_int_reg   [3];
    logic [INT_W-1:0] s2_int_next  [3];
    logic [Q_W-1:0]   s2_frac_reg  [3];
    logic [Q_W-1:0]   s2_frac_next [3];

    always_comb
    begin
        logic signed [SUM_W-1:0]     ta;
        logic signed [SUM_W-1:0]     sum;
        logic [COORD_W-1:0]          crd;
        logic [COORD_W+Q_W-1:0]      wide;
        ta = (SUM_W'(s1_time_reg) <<< TA_SHL) >>> TA_SHR;
        for (int a = 0; a < 3; a++)
        begin
            sum = SUM_W'(s1_prod_reg[a] >>> SCALE_SHR);
            if (a == 0)
            begin
                sum = sum + ta;
            end
            if (!sum[SUM_W-1] && (|sum[SUM_W-2:COORD_W-1]))
            begin
                crd = COORD_MAX;
            end
            else if (sum[SUM_W-1] && !(&sum[SUM_W-2:COORD_W-1]))
            begin
                crd = COORD_MIN;
            end
            else
            begin
                crd = sum[COORD_W-1:0];
            end
            // fraction padded or truncated to q0.16
            wide            = {crd, {Q_W{1'b0}}};
            s2_int_next[a]  = crd[COORD_W-1:FRAC_BITS];
            s2_frac_next[a] = wide[FRAC_BITS+Q_W-1 -: Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_int_reg  <= s2_int_next;
            s2_frac_reg <= s2_frac_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: per-axis hash products, fade first step
    // ------------------------------------------------------------------
    logic [31:0]             s3_hk_reg  [3];
    logic [31:0]             s3_hk_next [3];
    logic signed [FA_W-1:0]  s3_fa_reg  [3];
    logic signed [FA_W-1:0]  s3_fa_next [3];
    logic [Q_W-1:0]          s3_t2_reg  [3];
    logic [Q_W-1:0]          s3_t2_next [3];
    logic [Q_W-1:0]          s3_t_reg   [3];

    always_comb
    begin
        logic [COORD_W-1:0] ie;
        logic [2*Q_W-1:0]   sq;
        for (int a = 0; a < 3; a++)
        begin
            ie = {{FRAC_BITS{s2_int_reg[a][INT_W-1]}}, s2_int_reg[a]};
            case (a)
                0:       s3_hk_next[a] = ie * HASH_KX;
                1:       s3_hk_next[a] = ie * HASH_KY;
                default: s3_hk_next[a] = ie * HASH_KZ;
            endcase
            s3_fa_next[a] = $signed({{(FA_W-Q_W){1'b0}}, s2_frac_reg[a]}) * FADE_MUL6
                            - FADE_K15;
            sq            = s2_frac_reg[a] * s2_frac_reg[a];
            s3_t2_next[a] = sq[2*Q_W-1:Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_hk_reg <= s3_hk_next;
            s3_fa_reg <= s3_fa_next;
            s3_t2_reg <= s3_t2_next;
            s3_t_reg  <= s2_frac_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: corner hash sums and first xorshift, fade second step
    // ------------------------------------------------------------------
    logic [31:0]            s4_h_reg   [8];
    logic [31:0]            s4_h_next  [8];
    logic signed [FA_W-1:0] s4_fb_reg  [3];
    logic signed [FA_W-1:0] s4_fb_next [3];
    logic [Q_W-1:0]         s4_t3_reg  [3];
    logic [Q_W-1:0]         s4_t3_next [3];
    logic [Q_W-1:0]         s4_t_reg   [3];

    always_comb
    begin
        logic [31:0]            hx;
        logic [31:0]            hy;
        logic [31:0]            hz;
        logic [31:0]            hs;
        logic signed [FP_W-1:0] p;
        logic [2*Q_W-1:0]       cu;
        for (int i = 0; i < 8; i++)
        begin
            // corner index bit 0 picks x+1, bit 1 y+1, bit 2 z+1
            hx = i[0] ? s3_hk_reg[0] + HASH_KX : s3_hk_reg[0];
            hy = i[1] ? s3_hk_reg[1] + HASH_KY : s3_hk_reg[1];
            hz = i[2] ? s3_hk_reg[2] + HASH_KZ : s3_hk_reg[2];
            hs = hx + hy + hz;
            s4_h_next[i] = hs ^ (hs >> 13);
        end
        for (int a = 0; a < 3; a++)
        begin
            p             = $signed({1'b0, s3_t_reg[a]}) * s3_fa_reg[a];
            s4_fb_next[a] = $signed(p[FA_W+Q_W-1:Q_W]) + FADE_K10;
            cu            = s3_t2_reg[a] * s3_t_reg[a];
            s4_t3_next[a] = cu[2*Q_W-1:Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_h_reg  <= s4_h_next;
            s4_fb_reg <= s4_fb_next;
            s4_t3_reg <= s4_t3_next;
            s4_t_reg  <= s3_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: hash multiply, corner value is the top half, fade third step
    // ------------------------------------------------------------------
    logic [Q_W-1:0]         s5_cv_reg  [8];
    logic [Q_W-1:0]         s5_cv_next [8];
    logic signed [FA_W-1:0] s5_fc_reg  [3];
    logic signed [FA_W-1:0] s5_fc_next [3];
    logic [Q_W-1:0]         s5_t3_reg  [3];

    always_comb
    begin
        logic [31:0]            hm;
        logic signed [FP_W-1:0] p;
        for (int i = 0; i < 8; i++)
        begin
            // the final xorshift by 16 leaves the top half unchanged
            hm            = s4_h_reg[i] * HASH_KM;
            s5_cv_next[i] = hm[31:16];
        end
        for (int a = 0; a < 3; a++)
        begin
            p             = $signed({1'b0, s4_t_reg[a]}) * s4_fb_reg[a];
            s5_fc_next[a] = $signed(p[FA_W+Q_W-1:Q_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_cv_reg <= s5_cv_next;
            s5_fc_reg <= s5_fc_next;
            s5_t3_reg <= s4_t3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: fade last product and clamp
    // ------------------------------------------------------------------
    logic [Q_W-1:0] s6_cv_reg    [8];
    logic [Q_W-1:0] s6_fade_reg  [3];
    logic [Q_W-1:0] s6_fade_next [3];

    always_comb
    begin
        logic signed [FP_W-1:0] p;
        logic signed [FA_W-1:0] q;
        for (int a = 0; a < 3; a++)
        begin
            p = $signed({1'b0, s5_t3_reg[a]}) * s5_fc_reg[a];
            q = $signed(p[FA_W+Q_W-1:Q_W]);
            if (q < 0)
            begin
                s6_fade_next[a] = '0;
            end
            else if (q > FADE_MAX)
            begin
                s6_fade_next[a] = '1;
            end
            else
            begin
                s6_fade_next[a] = q[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_cv_reg   <= s5_cv_reg;
            s6_fade_reg <= s6_fade_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: blend along x
    // ------------------------------------------------------------------
    logic [Q_W-1:0] s7_ix_reg  [4];
    logic [Q_W-1:0] s7_ix_next [4];
    logic [Q_W-1:0] s7_ty_reg;
    logic [Q_W-1:0] s7_tz_reg;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            s7_ix_next[j] = lerp(s6_cv_reg[2*j], s6_cv_reg[2*j+1], s6_fade_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s7_ix_reg <= s7_ix_next;
            s7_ty_reg <= s6_fade_reg[1];
            s7_tz_reg <= s6_fade_reg[2];
        end
    end

    // ------------------------------------------------------------------
    // stage 8: blend along y
    // ------------------------------------------------------------------
    logic [Q_W-1:0] s8_jy_reg  [2];
    logic [Q_W-1:0] s8_jy_next [2];
    logic [Q_W-1:0] s8_tz_reg;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            s8_jy_next[j] = lerp(s7_ix_reg[2*j], s7_ix_reg[2*j+1], s7_ty_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s8_jy_reg <= s8_jy_next;
            s8_tz_reg <= s7_tz_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: blend along z, output register
    // ------------------------------------------------------------------
    logic [Q_W-1:0] s9_noise_reg;
    logic [Q_W-1:0] s9_noise_next;

    assign s9_noise_next = lerp(s8_jy_reg[0], s8_jy_reg[1], s8_tz_reg);

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s9_noise_reg <= s9_noise_next;
        end
    end

    assign noise_value = s9_noise_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // input is only held back when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
    else $error("input stalled with room in the pipeline");

    // items in flight change only by input and output transfers
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(vld_reg) ==
             $countones($past(vld_reg))
             + ($past(in_valid && !in_stall) ? 1 : 0)
             - ($past(out_valid && !out_stall) ? 1 : 0)))
    else $error("pipeline lost or duplicated an item");

    // a held output keeps the same noise value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (vld_reg[STAGES-1] && $stable(s9_noise_reg)))
    else $error("stalled result changed in the output register");

endmodule

`default_nettype wire
